>>> rtl/core/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants for the serial packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int          MAX_PAYLOAD_DEF  = 32;
    localparam logic [7:0]  HEADER_RESET     = 8'hAA;
    localparam logic [5:0]  MAX_LENGTH_RESET = 6'd32;

    localparam int CFG_DATA_W = 8;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_BYTE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH  = 1'b1;

    localparam logic STATUS_GOOD     = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load_hdr;
        logic load_len;
        logic store_byte;
        logic check;
        logic load_err;
        logic drain_step;
    } spd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hdr_match;
        logic len_ok;
        logic data_done;
        logic sum_match;
        logic drain_last;
        logic out_free;
    } spd_stat_t;

endpackage

>>> rtl/core/spd_ctrl.sv
// ----------------------------------------------------------------------------
// spd_ctrl
// Frame phase sequencer: hunt, length, payload, checksum, payload drain.
// ----------------------------------------------------------------------------
module spd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  spd_pkg::spd_stat_t stat,
    output spd_pkg::spd_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_HUNT  = 5'b00001,
        ST_LEN   = 5'b00010,
        ST_DATA  = 5'b00100,
        ST_SUM   = 5'b01000,
        ST_DRAIN = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_HUNT:
            begin
                in_ready = 1'b1;
                if (in_fire && stat.hdr_match)
                begin
                    cmd.load_hdr = 1'b1;
                    state_next   = ST_LEN;
                end
            end
            ST_LEN:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    if (stat.len_ok)
                    begin
                        cmd.load_len = 1'b1;
                        state_next   = ST_DATA;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_DATA:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.store_byte = 1'b1;
                    if (stat.data_done)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                in_ready = stat.out_free;
                if (in_fire)
                begin
                    cmd.check = 1'b1;
                    if (stat.sum_match)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        cmd.load_err = 1'b1;
                        state_next   = ST_HUNT;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (stat.out_free)
                begin
                    cmd.drain_step = 1'b1;
                    if (stat.drain_last)
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/spd_datapath.sv
// ----------------------------------------------------------------------------
// spd_datapath
// Config registers, length/count/sum registers, payload store, result register.
// ----------------------------------------------------------------------------
module spd_datapath
#(
    parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [spd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [spd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [7:0]                      rx_byte,
    input  spd_pkg::spd_cmd_t               cmd,
    output spd_pkg::spd_stat_t              stat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_status,
    output logic [7:0]                      out_payload,
    output logic [4:0]                      out_pos,
    output logic [5:0]                      out_len,
    output logic                            out_last
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0] header_reg;
    logic [5:0] max_len_reg;
    logic [5:0] expected_len_reg;
    logic [5:0] byte_count_reg;
    logic [7:0] running_sum_reg;
    logic [5:0] rd_cnt_reg;
    logic       out_valid_reg;
    logic       out_status_reg;
    logic [7:0] out_payload_reg;
    logic [4:0] out_pos_reg;
    logic [5:0] out_len_reg;
    logic       out_last_reg;

    logic [7:0] mem [MAX_PAYLOAD];

    logic [5:0] count_inc;
    logic [5:0] rd_inc;
    logic       store_en;
    logic       load_err_q;
    logic       drain_q;

    assign count_inc = byte_count_reg + 6'd1;
    assign rd_inc    = rd_cnt_reg + 6'd1;
    assign store_en  = cmd.store_byte && ({1'b0, byte_count_reg} < 7'(MAX_PAYLOAD));
    assign load_err_q = cmd.load_err;
    assign drain_q    = cmd.drain_step;

    always_comb
    begin
        stat.hdr_match  = (rx_byte == header_reg);
        stat.len_ok     = (rx_byte != 8'd0) && (rx_byte <= {2'b00, max_len_reg})
                          && (rx_byte <= 8'(MAX_PAYLOAD));
        stat.data_done  = (count_inc >= expected_len_reg);
        stat.sum_match  = (rx_byte == running_sum_reg);
        stat.drain_last = (rd_inc >= expected_len_reg);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg       <= spd_pkg::HEADER_RESET;
            max_len_reg      <= spd_pkg::MAX_LENGTH_RESET;
            expected_len_reg <= '0;
            byte_count_reg   <= '0;
            running_sum_reg  <= '0;
            rd_cnt_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    spd_pkg::REG_HEADER_BYTE: header_reg  <= cfg_wdata;
                    spd_pkg::REG_MAX_LENGTH:  max_len_reg <= cfg_wdata[5:0];
                    default: ;
                endcase
            end

            if (cmd.load_hdr)
            begin
                running_sum_reg <= rx_byte;
            end
            else if (cmd.load_len)
            begin
                expected_len_reg <= rx_byte[5:0];
                byte_count_reg   <= '0;
                running_sum_reg  <= running_sum_reg + rx_byte;
            end
            else if (cmd.store_byte)
            begin
                byte_count_reg  <= count_inc;
                running_sum_reg <= running_sum_reg + rx_byte;
            end
            else if (cmd.check)
            begin
                byte_count_reg  <= '0;
                running_sum_reg <= '0;
            end

            if (cmd.check)
            begin
                rd_cnt_reg <= '0;
            end
            else if (drain_q)
            begin
                rd_cnt_reg <= rd_inc;
            end

            if (load_err_q || drain_q)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload store and registered read into the result register
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[byte_count_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (load_err_q)
        begin
            out_status_reg  <= spd_pkg::STATUS_MISMATCH;
            out_payload_reg <= '0;
            out_pos_reg     <= '0;
            out_len_reg     <= expected_len_reg;
            out_last_reg    <= 1'b1;
        end
        else if (drain_q)
        begin
            out_status_reg  <= spd_pkg::STATUS_GOOD;
            out_payload_reg <= mem[rd_cnt_reg[ADDR_W-1:0]];
            out_pos_reg     <= rd_cnt_reg[4:0];
            out_len_reg     <= expected_len_reg;
            out_last_reg    <= (rd_inc == expected_len_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_payload = out_payload_reg;
    assign out_pos     = out_pos_reg;
    assign out_len     = out_len_reg;
    assign out_last    = out_last_reg;

endmodule

>>> rtl/core/serial_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// serial_packet_deframer_unit
// Header / length / payload / sum8 checksum deframer on byte streams.
// ----------------------------------------------------------------------------
// Header, length and payload bytes are taken one per cycle. The checksum byte
// is taken once the result register is free. A good frame of N payload bytes
// is then drained from the payload store at one store read per cycle, with the
// input held off; downstream stalls stretch this. A bad checksum gives a single
// result with tuser set and no drain. The last result of a run may still wait
// in the result register while hunting resumes.
module serial_packet_deframer_unit
#(
    parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [spd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [spd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // rx_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,  // payload_byte, byte_position, frame_length
    output logic                           m_axis_tuser,  // status
    output logic                           m_axis_tlast
);

    spd_pkg::spd_cmd_t  cmd;
    spd_pkg::spd_stat_t stat;
    logic [7:0]         out_payload;
    logic [4:0]         out_pos;
    logic [5:0]         out_len;

    spd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spd_datapath
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .rx_byte     (s_axis_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (m_axis_tuser),
        .out_payload (out_payload),
        .out_pos     (out_pos),
        .out_len     (out_len),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, out_len, out_pos, out_payload};

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tlast && m_axis_tdata[12:0] == 13'd0))
        else $error("mismatch result not a zeroed single-item run");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser && m_axis_tlast) |->
            (5'(m_axis_tdata[12:8] + 5'd1) == m_axis_tdata[17:13]))
        else $error("last payload result at wrong position");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[18:13] != 6'd0))
        else $error("result with zero frame length");

    a_drain_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tuser && !m_axis_tlast)
            |=> m_axis_tvalid)
        else $error("payload drain left a gap");

    a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input taken while a payload run is incomplete");

endmodule
